// ----- hw/rtl/lpg_pkg.sv -----
// shared types and codes for the lexicographic permutation generator
// no dependencies; every other file refers to it by scoped names
package lpg_pkg;

  localparam int ELEM_W = 16;

  // item codes on the command channel
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic                     wrapped;
    logic                     overflow;
    logic                     empty_res;
  } lpg_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_W2,
    ST_PIV_RD,
    ST_PIV_CMP,
    ST_EMIT_PRE,
    ST_EMIT,
    ST_SUCC_RD,
    ST_SUCC_CMP,
    ST_SWAP_W2,
    ST_REV_RD,
    ST_REV_W1,
    ST_REV_W2
  } state_t;

endpackage

// ----- hw/rtl/lpg_if.sv -----
// valid/ready stream interfaces for the command and result channels
// depends on lpg_pkg for the payload width
interface lpg_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [lpg_pkg::ELEM_W-1:0] value;
  logic                             first;

  modport source (output valid, mode, value, first, input ready);
  modport sink   (input valid, mode, value, first, output ready);
endinterface

interface lpg_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpg_pkg::ELEM_W-1:0] element;
  logic                             last;
  logic                             wrapped;
  logic                             overflow;
  logic                             empty_res;

  modport source (output valid, element, last, wrapped, overflow, empty_res, input ready);
  modport sink   (input valid, element, last, wrapped, overflow, empty_res, output ready);
endinterface

// ----- hw/rtl/lpg_out_buf.sv -----
// two-entry result queue that drives the result channel
// depends on lpg_pkg (lpg_res_t) and lpg_out_if
module lpg_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpg_pkg::lpg_res_t push_data,
  output logic              can_push,
  lpg_out_if.source         res
);

  lpg_pkg::lpg_res_t slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              do_push;
  logic              do_pop;
  lpg_pkg::lpg_res_t head;

  assign can_push = (fill != 2'd2);
  assign do_push  = push && can_push;
  assign do_pop   = res.valid && res.ready;
  assign head     = slot[rd_ptr];

  assign res.valid     = (fill != 2'd0);
  assign res.element   = head.element;
  assign res.last      = head.last;
  assign res.wrapped   = head.wrapped;
  assign res.overflow  = head.overflow;
  assign res.empty_res = head.empty_res;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lexicographic_permutation_generator_core.sv -----
// top level of the permutation generator: sequencer, element store, shared comparator
// depends on lpg_pkg, lpg_if and lpg_out_buf
//
// usage
//   cmd channel (lpg_in_if): one beat per item. mode load appends value to the store
//   (first empties it before the write); mode advance emits the current arrangement
//   and steps it to the lexicographically next one, equal values counted once.
//   res channel (lpg_out_if): one beat per emitted element, last on the final beat
//   of an item; wrapped on every beat when the arrangement was the final one;
//   a load into a full store gives one overflow beat, an advance on an empty
//   store one empty_res beat.
// timing
//   a load is taken in the idle state and cmd.ready stays high. a load into a full store and an
//   advance on an empty store hold cmd.ready low while their single beat is
//   queued, longer while the queue is full. an advance on n elements holds
//   cmd.ready low for: the pivot scan (a read and a compare per step, at most n-1
//   steps), priming the store read, the emit of n elements, then the successor scan
//   (read and compare per step), the swap, the suffix swaps (at most n/2), and exit.
//   the first advance after loads also runs an insertion sort: a read and a compare
//   per compare step, and one more write per swap. the store has one write
//   port and two registered read ports, which sets the step structure above.
// reset
//   rst (synchronous) empties the store and clears the result queue; the store
//   contents are not cleared, only the count.
// stall
//   results go through a two-entry queue; while it is full the emit step waits and
//   nothing is lost or repeated.
module lexicographic_permutation_generator_core #(
  parameter int MAX_ELEMENTS = 8,
  parameter int VALUE_BITS   = 16
) (
  input logic       clk,
  input logic       rst,
  lpg_in_if.sink    cmd,
  lpg_out_if.source res
);

  localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int LOW_BITS = (VALUE_BITS < lpg_pkg::ELEM_W) ? VALUE_BITS : lpg_pkg::ELEM_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  // control state
  lpg_pkg::state_t  state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             sorted, sorted_next;
  logic [CNT_W-1:0] i_idx, i_next;     // sort outer index, then pivot index
  logic [CNT_W-1:0] j_idx, j_next;     // sort inner index, then successor index
  logic [CNT_W-1:0] k_idx, k_next;     // emit position
  logic [CNT_W-1:0] lo, lo_next;       // reverse window, inclusive low
  logic [CNT_W-1:0] hi, hi_next;       // reverse window, exclusive high
  logic             wrap, wrap_next;
  logic             resp_ovf, resp_ovf_next;

  // payload holding registers
  logic signed [VALUE_BITS-1:0] pivot_val, pivot_val_next;
  logic signed [VALUE_BITS-1:0] tmp, tmp_next;

  // element store: one write port, two registered read ports
  logic signed [VALUE_BITS-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_BITS-1:0] qa, qb;
  logic [IDX_W-1:0]             ra, rb, wa;
  logic                         we;
  logic signed [VALUE_BITS-1:0] wd;

  // shared comparator
  logic signed [VALUE_BITS-1:0] cmp_a, cmp_b;
  logic                         gt;

  // helpers
  logic [CNT_W-1:0]             cnt_eff, i_inc, i_dec, j_dec, k_inc, hi_dec, lo_inc;
  logic                         rev_more;
  logic signed [VALUE_BITS-1:0] load_val;
  logic [lpg_pkg::ELEM_W-1:0]   elem_out;

  logic              push;
  lpg_pkg::lpg_res_t push_data;
  logic              can_push;

  lpg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .res       (res)
  );

  assign cnt_eff  = cmd.first ? '0 : count;
  assign i_inc    = i_idx + 1'b1;
  assign i_dec    = i_idx - 1'b1;
  assign j_dec    = j_idx - 1'b1;
  assign k_inc    = k_idx + 1'b1;
  assign hi_dec   = hi - 1'b1;
  assign lo_inc   = lo + 1'b1;
  assign rev_more = ({1'b0, lo} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, hi};

  // value field to store width, and store width back to the 16-bit element
  always_comb begin
    load_val = '0;
    for (int b = 0; b < LOW_BITS; b++) begin
      load_val[b] = cmd.value[b];
    end
    elem_out = {lpg_pkg::ELEM_W{qa[VALUE_BITS-1]}};
    for (int b = 0; b < LOW_BITS; b++) begin
      elem_out[b] = qa[b];
    end
  end

  // comparator operand select: sort asks s[j-1] > s[j], pivot scan s[i] > s[i-1],
  // successor scan s[j] > pivot
  always_comb begin
    cmp_a = qa;
    cmp_b = qb;
    case (state)
      lpg_pkg::ST_PIV_CMP: begin
        cmp_a = qb;
        cmp_b = qa;
      end
      lpg_pkg::ST_SUCC_CMP: begin
        cmp_a = qa;
        cmp_b = pivot_val;
      end
      default: begin
        cmp_a = qa;
        cmp_b = qb;
      end
    endcase
  end
  assign gt = cmp_a > cmp_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpg_pkg::ST_IDLE;
      count    <= '0;
      sorted   <= 1'b0;
      i_idx    <= '0;
      j_idx    <= '0;
      k_idx    <= '0;
      lo       <= '0;
      hi       <= '0;
      wrap     <= 1'b0;
      resp_ovf <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      sorted   <= sorted_next;
      i_idx    <= i_next;
      j_idx    <= j_next;
      k_idx    <= k_next;
      lo       <= lo_next;
      hi       <= hi_next;
      wrap     <= wrap_next;
      resp_ovf <= resp_ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    pivot_val <= pivot_val_next;
    tmp       <= tmp_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    sorted_next    = sorted;
    i_next         = i_idx;
    j_next         = j_idx;
    k_next         = k_idx;
    lo_next        = lo;
    hi_next        = hi;
    wrap_next      = wrap;
    resp_ovf_next  = resp_ovf;
    pivot_val_next = pivot_val;
    tmp_next       = tmp;
    ra             = '0;
    rb             = '0;
    we             = 1'b0;
    wa             = '0;
    wd             = qa;
    push           = 1'b0;
    push_data      = '0;
    cmd.ready      = (state == lpg_pkg::ST_IDLE);

    case (state)
      lpg_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.mode == lpg_pkg::MODE_LOAD) begin
            if (cnt_eff >= MAX_CNT) begin
              resp_ovf_next = 1'b1;
              state_next    = lpg_pkg::ST_RESP;
            end else begin
              we          = 1'b1;
              wa          = cnt_eff[IDX_W-1:0];
              wd          = load_val;
              count_next  = cnt_eff + 1'b1;
              sorted_next = 1'b0;
            end
          end else if (count == '0) begin
            resp_ovf_next = 1'b0;
            state_next    = lpg_pkg::ST_RESP;
          end else begin
            sorted_next = 1'b1;
            if (count == CNT_W'(1)) begin
              // a single element is its own last arrangement
              wrap_next  = 1'b1;
              state_next = lpg_pkg::ST_EMIT_PRE;
            end else if (!sorted) begin
              i_next     = CNT_W'(1);
              j_next     = CNT_W'(1);
              state_next = lpg_pkg::ST_SORT_RD;
            end else begin
              i_next     = count - 1'b1;
              state_next = lpg_pkg::ST_PIV_RD;
            end
          end
        end
      end

      lpg_pkg::ST_RESP: begin
        push                = 1'b1;
        push_data.last      = 1'b1;
        push_data.overflow  = resp_ovf;
        push_data.empty_res = ~resp_ovf;
        if (can_push) begin
          state_next = lpg_pkg::ST_IDLE;
        end
      end

      // insertion sort: each compare reads in SORT_RD and compares in SORT_CMP
      lpg_pkg::ST_SORT_RD: begin
        ra         = j_dec[IDX_W-1:0];
        rb         = j_idx[IDX_W-1:0];
        state_next = lpg_pkg::ST_SORT_CMP;
      end

      lpg_pkg::ST_SORT_CMP: begin
        if (gt) begin
          we         = 1'b1;
          wa         = j_dec[IDX_W-1:0];
          wd         = qb;
          tmp_next   = qa;
          state_next = lpg_pkg::ST_SORT_W2;
        end else if (i_inc == count) begin
          i_next     = count - 1'b1;
          state_next = lpg_pkg::ST_PIV_RD;
        end else begin
          i_next     = i_inc;
          j_next     = i_inc;
          state_next = lpg_pkg::ST_SORT_RD;
        end
      end

      lpg_pkg::ST_SORT_W2: begin
        we     = 1'b1;
        wa     = j_idx[IDX_W-1:0];
        wd     = tmp;
        j_next = j_dec;
        if (j_dec != '0) begin
          state_next = lpg_pkg::ST_SORT_RD;
        end else if (i_inc == count) begin
          i_next     = count - 1'b1;
          state_next = lpg_pkg::ST_PIV_RD;
        end else begin
          i_next     = i_inc;
          j_next     = i_inc;
          state_next = lpg_pkg::ST_SORT_RD;
        end
      end

      // scan from the right for the first ascent s[i-1] < s[i]
      lpg_pkg::ST_PIV_RD: begin
        ra         = i_dec[IDX_W-1:0];
        rb         = i_idx[IDX_W-1:0];
        state_next = lpg_pkg::ST_PIV_CMP;
      end

      lpg_pkg::ST_PIV_CMP: begin
        if (gt) begin
          pivot_val_next = qa;
          wrap_next      = 1'b0;
          state_next     = lpg_pkg::ST_EMIT_PRE;
        end else if (i_dec == '0) begin
          wrap_next  = 1'b1;
          state_next = lpg_pkg::ST_EMIT_PRE;
        end else begin
          i_next     = i_dec;
          state_next = lpg_pkg::ST_PIV_RD;
        end
      end

      lpg_pkg::ST_EMIT_PRE: begin
        ra         = '0;
        k_next     = '0;
        state_next = lpg_pkg::ST_EMIT;
      end

      // one element per cycle while the queue has room
      lpg_pkg::ST_EMIT: begin
        push              = 1'b1;
        push_data.element = elem_out;
        push_data.last    = (k_inc == count);
        push_data.wrapped = wrap;
        ra                = (can_push && (k_inc != count)) ? k_inc[IDX_W-1:0]
                                                           : k_idx[IDX_W-1:0];
        if (can_push) begin
          if (k_inc == count) begin
            if (wrap) begin
              lo_next    = '0;
              hi_next    = count;
              state_next = lpg_pkg::ST_REV_RD;
            end else begin
              j_next     = count - 1'b1;
              state_next = lpg_pkg::ST_SUCC_RD;
            end
          end else begin
            k_next = k_inc;
          end
        end
      end

      // rightmost element above the pivot
      lpg_pkg::ST_SUCC_RD: begin
        ra         = j_idx[IDX_W-1:0];
        state_next = lpg_pkg::ST_SUCC_CMP;
      end

      lpg_pkg::ST_SUCC_CMP: begin
        if (gt) begin
          we         = 1'b1;
          wa         = i_dec[IDX_W-1:0];
          wd         = qa;
          state_next = lpg_pkg::ST_SWAP_W2;
        end else begin
          j_next     = j_dec;
          state_next = lpg_pkg::ST_SUCC_RD;
        end
      end

      lpg_pkg::ST_SWAP_W2: begin
        we         = 1'b1;
        wa         = j_idx[IDX_W-1:0];
        wd         = pivot_val;
        lo_next    = i_idx;
        hi_next    = count;
        state_next = lpg_pkg::ST_REV_RD;
      end

      // reverse lo..hi-1 by swapping the ends inward
      lpg_pkg::ST_REV_RD: begin
        if (rev_more) begin
          ra         = lo[IDX_W-1:0];
          rb         = hi_dec[IDX_W-1:0];
          state_next = lpg_pkg::ST_REV_W1;
        end else begin
          state_next = lpg_pkg::ST_IDLE;
        end
      end

      lpg_pkg::ST_REV_W1: begin
        we         = 1'b1;
        wa         = lo[IDX_W-1:0];
        wd         = qb;
        tmp_next   = qa;
        state_next = lpg_pkg::ST_REV_W2;
      end

      lpg_pkg::ST_REV_W2: begin
        we         = 1'b1;
        wa         = hi_dec[IDX_W-1:0];
        wd         = tmp;
        lo_next    = lo_inc;
        hi_next    = hi_dec;
        state_next = lpg_pkg::ST_REV_RD;
      end

      default: begin
        state_next = lpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/lpg_checker.sv -----
// port-level assertions for the permutation generator, bound to the top level
// depends on lpg_pkg and lexicographic_permutation_generator_core
module lpg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cmd_valid,
  input logic                             cmd_ready,
  input logic                             cmd_mode,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic signed [lpg_pkg::ELEM_W-1:0] res_element,
  input logic                             res_last,
  input logic                             res_wrapped,
  input logic                             res_overflow,
  input logic                             res_empty_res
);

  // a stalled result beat stays offered
  a_res_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat withdrawn while stalled");

  // a stalled result beat keeps its payload
  a_res_hold_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_element) && $stable(res_last)
      && $stable(res_wrapped) && $stable(res_overflow) && $stable(res_empty_res))
    else $error("result payload changed while stalled");

  // an advance always occupies the sequencer
  a_advance_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_mode == lpg_pkg::MODE_ADVANCE) |=> !cmd_ready)
    else $error("command accepted back to back with an advance");

  // overflow and empty beats are single, flagless, zero-element beats
  a_flag_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_overflow || res_empty_res) |->
      res_last && !res_wrapped && (res_element == '0) && !(res_overflow && res_empty_res))
    else $error("malformed overflow or empty beat");

endmodule

bind lexicographic_permutation_generator_core lpg_checker u_lpg_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_mode      (cmd.mode),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_element   (res.element),
  .res_last      (res.last),
  .res_wrapped   (res.wrapped),
  .res_overflow  (res.overflow),
  .res_empty_res (res.empty_res)
);

// ----- bench/lexicographic_permutation_generator_core_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for lexicographic_permutation_generator_core: directed and random
// load/advance traffic, with results checked against a behavioral permutation stepper
// depends on lpg_pkg, lpg_if (lpg_in_if, lpg_out_if) and the core itself
module lexicographic_permutation_generator_core_test;

  localparam int STORE_DEPTH    = 8;
  localparam int VALUE_WIDTH    = 16;
  localparam int FIELD_W        = lpg_pkg::ELEM_W;
  localparam int RANDOM_ITEMS   = 350;
  localparam int WATCHDOG_LIMIT = 3000;
  // tail of an advance (successor scan, swap, suffix reversal) after its last beat
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN
  } ready_style_t;

  logic clk;
  logic rst;

  lpg_in_if  cmd_ch ();
  lpg_out_if res_ch ();

  lexicographic_permutation_generator_core #(
    .MAX_ELEMENTS(STORE_DEPTH),
    .VALUE_BITS  (VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // behavioral copy of the element store
  logic signed [FIELD_W-1:0] perm_store [STORE_DEPTH];
  int                        perm_count  = 0;
  bit                        perm_sorted = 1'b0;

  // beats still owed by the core, oldest first
  lpg_pkg::lpg_res_t expected_beats [$];

  int fail_count   = 0;
  int report_count = 0;
  int items_sent   = 0;
  int beats_seen   = 0;

  // sender burst state
  int burst_left = 0;
  bit send_gaps  = 1'b0;

  // receiver stall state
  ready_style_t ready_style   = RDY_ALWAYS;
  logic [7:0]   stall_pattern = 8'hff;
  logic [2:0]   pattern_phase = '0;
  int           stall_left    = 0;

  int                quiet_cycles;
  lpg_pkg::lpg_res_t seen_beat;
  lpg_pkg::lpg_res_t want_beat;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  // appends one beat to the owed list
  function automatic void owe_beat(input lpg_pkg::lpg_res_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // works out the beats one accepted command causes and steps the store copy
  function automatic void predict_item(input logic m, input logic signed [FIELD_W-1:0] v,
                                       input logic f);
    lpg_pkg::lpg_res_t         beat;
    logic signed [FIELD_W-1:0] shown [STORE_DEPTH];
    logic signed [FIELD_W-1:0] tmp;
    int                        i;
    int                        j;
    int                        lo;
    int                        hi;
    bit                        wrap;
    if (m == lpg_pkg::MODE_LOAD) begin
      if (f) begin
        perm_count  = 0;
        perm_sorted = 1'b0;
      end
      if (perm_count >= STORE_DEPTH) begin
        // full store: value dropped, single overflow beat
        beat          = '0;
        beat.last     = 1'b1;
        beat.overflow = 1'b1;
        owe_beat(beat);
      end else begin
        perm_store[perm_count] = v;
        perm_count++;
        perm_sorted = 1'b0;
      end
    end else if (perm_count == 0) begin
      beat           = '0;
      beat.last      = 1'b1;
      beat.empty_res = 1'b1;
      owe_beat(beat);
    end else begin
      // insertion sort on the first advance after loading
      if (!perm_sorted) begin
        for (i = 1; i < perm_count; i++) begin
          j = i;
          while (j > 0 && perm_store[j-1] > perm_store[j]) begin
            tmp             = perm_store[j-1];
            perm_store[j-1] = perm_store[j];
            perm_store[j]   = tmp;
            j--;
          end
        end
        perm_sorted = 1'b1;
      end
      shown = perm_store;
      // pivot: rightmost position with a strictly larger right neighbor
      i = perm_count - 1;
      while (i > 0 && perm_store[i-1] >= perm_store[i]) i--;
      wrap = (i == 0);
      if (!wrap) begin
        j = perm_count - 1;
        while (perm_store[j] <= perm_store[i-1]) j--;
        tmp             = perm_store[i-1];
        perm_store[i-1] = perm_store[j];
        perm_store[j]   = tmp;
      end
      // suffix reversal, whole store on a wrap
      lo = i;
      hi = perm_count - 1;
      while (lo < hi) begin
        tmp            = perm_store[lo];
        perm_store[lo] = perm_store[hi];
        perm_store[hi] = tmp;
        lo++;
        hi--;
      end
      for (i = 0; i < perm_count; i++) begin
        beat         = '0;
        beat.element = shown[i];
        beat.last    = (i == perm_count - 1);
        beat.wrapped = wrap;
        owe_beat(beat);
      end
    end
  endfunction

  // one command beat; bursts of random length with gaps in between when enabled
  task automatic send_cmd(input logic m, input logic signed [FIELD_W-1:0] v, input logic f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (send_gaps) begin
        gap = $urandom_range(1, 6);
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode  <= m;
    cmd_ch.value <= v;
    cmd_ch.first <= f;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_item(m, v, f);
    burst_left--;
    items_sent++;
  endtask

  // sender holds off until every owed beat has come back
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input bit gaps, input ready_style_t style);
    send_gaps     = gaps;
    ready_style   = style;
    stall_pattern = 8'($urandom_range(1, 255));
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_value(input int style);
    logic signed [FIELD_W-1:0] picked;
    case (style)
      0: picked = FIELD_W'($urandom_range(0, 4) - 2);
      1: picked = FIELD_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: picked = 16'sh8000;
          1: picked = 16'sh7fff;
          2: picked = '0;
          3: picked = '1;
          default: picked = FIELD_W'($urandom);
        endcase
      end
    endcase
    return picked;
  endfunction

  // advance with nothing stored, ignored fields set
  task automatic test_empty_store();
    send_cmd(lpg_pkg::MODE_ADVANCE, 16'sh7fff, 1'b1);
    send_cmd(lpg_pkg::MODE_ADVANCE, 16'sh8000, 1'b0);
  endtask

  // one element, then a set of equal values: only one arrangement, always wrapped
  task automatic test_single_and_equal();
    send_cmd(lpg_pkg::MODE_LOAD, -16'sd1, 1'b1);
    send_cmd(lpg_pkg::MODE_ADVANCE, '0, 1'b0);
    send_cmd(lpg_pkg::MODE_ADVANCE, '1, 1'b1);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sd7, 1'b1);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sd7, 1'b0);
    send_cmd(lpg_pkg::MODE_ADVANCE, '0, 1'b0);
  endtask

  // multiset of extremes: three arrangements then back to sorted
  task automatic test_multiset_cycle();
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh7fff, 1'b1);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh8000, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh7fff, 1'b0);
    repeat (4) send_cmd(lpg_pkg::MODE_ADVANCE, FIELD_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // fill, overflow, first-flagged load into the full store
  task automatic test_capacity();
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh0000, 1'b1);
    send_cmd(lpg_pkg::MODE_LOAD, -16'sd1, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh5555, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh2aaa, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh8000, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh7fff, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sd1, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, -16'sd2, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sh1357, 1'b0);
    send_cmd(lpg_pkg::MODE_ADVANCE, '0, 1'b0);
    send_cmd(lpg_pkg::MODE_LOAD, 16'sd3, 1'b1);
    send_cmd(lpg_pkg::MODE_ADVANCE, '0, 1'b0);
  endtask

  // random sets loaded and walked through their arrangements, with some noise
  task automatic test_random_sets();
    int target;
    int set_size;
    int vstyle;
    int perms;
    int advances;
    int k;
    int sets_done;
    target    = items_sent + RANDOM_ITEMS;
    sets_done = 0;
    while (items_sent < target) begin
      case ($urandom_range(0, 4))
        0: set_idling(1'b0, RDY_ALWAYS);
        1: set_idling(1'b1, RDY_ALWAYS);
        2: set_idling(1'b0, RDY_RANDOM);
        3: set_idling(1'b1, RDY_PATTERN);
        default: set_idling(1'b1, RDY_RANDOM);
      endcase
      // mostly small sets so that wraps are reached
      case ($urandom_range(0, 9))
        0: set_size = $urandom_range(7, 8);
        1, 2: set_size = $urandom_range(5, 6);
        default: set_size = $urandom_range(1, 4);
      endcase
      vstyle = $urandom_range(0, 2);
      for (k = 0; k < set_size; k++) begin
        send_cmd(lpg_pkg::MODE_LOAD, pick_value(vstyle), k == 0);
      end
      // loads past capacity
      if (set_size == STORE_DEPTH && $urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 2)) send_cmd(lpg_pkg::MODE_LOAD, pick_value(1), 1'b0);
      end
      perms = 1;
      for (k = 2; k <= set_size && perms < 30; k++) perms = perms * k;
      advances = (set_size <= 4) ? $urandom_range(1, perms + 1) : $urandom_range(1, 6);
      repeat (advances) begin
        send_cmd(lpg_pkg::MODE_ADVANCE, FIELD_W'($urandom), 1'($urandom_range(0, 1)));
      end
      // broken sequence: append after advancing, forces a fresh sort
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(lpg_pkg::MODE_LOAD, pick_value(vstyle), 1'b0);
        repeat ($urandom_range(1, 3)) begin
          send_cmd(lpg_pkg::MODE_ADVANCE, FIELD_W'($urandom), 1'($urandom_range(0, 1)));
        end
      end
      sets_done++;
      if (sets_done % 6 == 0) wait_for_results();
    end
  endtask

  // receiver ready: always, random with occasional long stalls, or a rotating pattern
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (ready_style)
        RDY_ALWAYS: res_ch.ready <= 1'b1;
        RDY_RANDOM: begin
          if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 49) == 0) begin
            stall_left = $urandom_range(4, 16);
            res_ch.ready <= 1'b0;
          end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= 30);
          end
        end
        default: begin
          res_ch.ready <= stall_pattern[pattern_phase];
          pattern_phase <= pattern_phase + 3'd1;
        end
      endcase
    end
  end

  // result checker: every accepted beat against the oldest owed beat
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_beat.element   = res_ch.element;
      seen_beat.last      = res_ch.last;
      seen_beat.wrapped   = res_ch.wrapped;
      seen_beat.overflow  = res_ch.overflow;
      seen_beat.empty_res = res_ch.empty_res;
      if (expected_beats.size() == 0) begin
        note_failure({$sformatf("unexpected beat %0d: element=%0d last=%b wrapped=%b ",
                                beats_seen, seen_beat.element, seen_beat.last,
                                seen_beat.wrapped),
                      $sformatf("overflow=%b empty_res=%b",
                                seen_beat.overflow, seen_beat.empty_res)});
      end else begin
        want_beat = expected_beats.pop_front();
        if (seen_beat.element !== want_beat.element || seen_beat.last !== want_beat.last ||
            seen_beat.wrapped !== want_beat.wrapped ||
            seen_beat.overflow !== want_beat.overflow ||
            seen_beat.empty_res !== want_beat.empty_res) begin
          note_failure({$sformatf("beat %0d mismatch: want element=%0d last=%b wrapped=%b ",
                                  beats_seen, want_beat.element, want_beat.last,
                                  want_beat.wrapped),
                        $sformatf("overflow=%b empty_res=%b, ",
                                  want_beat.overflow, want_beat.empty_res),
                        $sformatf("got element=%0d last=%b wrapped=%b ",
                                  seen_beat.element, seen_beat.last, seen_beat.wrapped),
                        $sformatf("overflow=%b empty_res=%b",
                                  seen_beat.overflow, seen_beat.empty_res)});
        end
      end
      beats_seen++;
    end
  end

  // watchdog: too long without any beat on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d beats owed", WATCHDOG_LIMIT,
             expected_beats.size());
    $display("lexicographic_permutation_generator_core verification failed");
    $finish;
  end

  initial begin
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode  <= lpg_pkg::MODE_LOAD;
    cmd_ch.value <= '0;
    cmd_ch.first <= 1'b0;
    rst          <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, first with a clean channel, then with gaps and receiver stalls
    set_idling(1'b0, RDY_ALWAYS);
    test_empty_store();
    test_single_and_equal();
    wait_for_results();
    set_idling(1'b1, RDY_RANDOM);
    test_multiset_cycle();
    wait_for_results();
    set_idling(1'b1, RDY_PATTERN);
    test_capacity();
    wait_for_results();

    test_random_sets();

    // drain, then let the last advance finish stepping
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lexicographic_permutation_generator_core verification clean");
    end else begin
      $display("lexicographic_permutation_generator_core verification failed");
    end
    $finish;
  end

endmodule
